@@ src/aclseq_pkg.sv @@
// ----------------------------------------------------------------------------
// aclseq_pkg
// Shared types, constants and word tables of the AT-command link sequencer.
// ----------------------------------------------------------------------------
package aclseq_pkg;

	localparam int MAX_LINE_CHARS_DEF = 512;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;

	localparam logic [7:0] WORD_OK [2] = '{8'h4F, 8'h4B};
	localparam logic [7:0] WORD_SENDOK [7] = '{8'h53, 8'h45, 8'h4E, 8'h44, 8'h5F, 8'h4F, 8'h4B};

	localparam logic [2:0] LINK_ECHO_OFF   = 3'd0;
	localparam logic [2:0] LINK_TEST       = 3'd1;
	localparam logic [2:0] LINK_MODE       = 3'd2;
	localparam logic [2:0] LINK_JOIN       = 3'd3;
	localparam logic [2:0] LINK_CONNECT    = 3'd4;
	localparam logic [2:0] LINK_NETWORK_UP = 3'd5;

	localparam logic [1:0] CMD_TEST    = 2'd0;
	localparam logic [1:0] CMD_MODE    = 2'd1;
	localparam logic [1:0] CMD_JOIN    = 2'd2;
	localparam logic [1:0] CMD_CONNECT = 2'd3;

	// Classification of one received byte, as passed from front to back.
	typedef struct packed {
		logic ok_line;
		logic sendok_line;
	} line_ev_t;

	typedef enum logic [5:0] {
		ST_ECHO_OFF   = 6'b000001,
		ST_TEST       = 6'b000010,
		ST_MODE       = 6'b000100,
		ST_JOIN       = 6'b001000,
		ST_CONNECT    = 6'b010000,
		ST_NETWORK_UP = 6'b100000
	} seq_state_t;

endpackage

@@ src/aclseq_front.sv @@
// ----------------------------------------------------------------------------
// aclseq_front
// Assembles received bytes into lines and classifies each byte.
// ----------------------------------------------------------------------------
module aclseq_front import aclseq_pkg::*; #(
	parameter int MAX_LINE_CHARS = MAX_LINE_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output line_ev_t   ev
);

	localparam int LEN_W = $clog2(MAX_LINE_CHARS);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE_CHARS - 1);
	localparam logic [LEN_W-1:0] LEN_OK = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_SENDOK = LEN_W'(7);

	logic [LEN_W-1:0] line_len_q;
	logic             ok_match_q;
	logic             sendok_match_q;
	logic             is_eol;
	logic             ok_char_hit;
	logic             sendok_char_hit;

	assign is_eol = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);

	always_comb begin
		ok_char_hit = 1'b0;
		sendok_char_hit = 1'b0;
		if (line_len_q < LEN_OK) begin
			ok_char_hit = (rx_byte == WORD_OK[line_len_q[0]]);
		end
		if (line_len_q < LEN_SENDOK) begin
			sendok_char_hit = (rx_byte == WORD_SENDOK[line_len_q[2:0]]);
		end
	end

	always_comb begin
		ev.ok_line = is_eol && ok_match_q && (line_len_q == LEN_OK);
		ev.sendok_line = is_eol && sendok_match_q && (line_len_q == LEN_SENDOK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			ok_match_q <= 1'b1;
			sendok_match_q <= 1'b1;
		end else if (take) begin
			if (is_eol) begin
				line_len_q <= '0;
				ok_match_q <= 1'b1;
				sendok_match_q <= 1'b1;
			end else if (line_len_q < LEN_LIMIT) begin
				line_len_q <= line_len_q + LEN_W'(1);
				ok_match_q <= ok_match_q && ok_char_hit;
				sendok_match_q <= sendok_match_q && sendok_char_hit;
			end
		end
	end

endmodule

@@ src/aclseq_fifo.sv @@
// ----------------------------------------------------------------------------
// aclseq_fifo
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module aclseq_fifo import aclseq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  line_ev_t push_ev,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output line_ev_t pop_ev
);

	line_ev_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_ev = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ src/aclseq_back.sv @@
// ----------------------------------------------------------------------------
// aclseq_back
// Bring-up sequencer, send counter and registered result stage.
// ----------------------------------------------------------------------------
module aclseq_back import aclseq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_avail,
	input  line_ev_t    ev,
	output logic        ev_take,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        cmd_valid,
	output logic [1:0]  cmd_index,
	output logic [2:0]  link_state,
	output logic [31:0] sends_confirmed
);

	seq_state_t  state_q;
	seq_state_t  state_nxt;
	logic [31:0] count_q;
	logic [31:0] count_nxt;
	logic        cmd_nxt;
	logic [1:0]  idx_nxt;
	logic [2:0]  link_nxt;
	logic        out_valid_q;

	assign ev_take = ev_avail && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		count_nxt = count_q;
		cmd_nxt = 1'b0;
		idx_nxt = CMD_TEST;
		if (state_q == ST_NETWORK_UP) begin
			if (ev.sendok_line) begin
				count_nxt = count_q + 32'd1;
			end
		end else if (ev.ok_line) begin
			case (state_q)
				ST_ECHO_OFF: begin
					state_nxt = ST_TEST;
					cmd_nxt = 1'b1;
					idx_nxt = CMD_TEST;
				end
				ST_TEST: begin
					state_nxt = ST_MODE;
					cmd_nxt = 1'b1;
					idx_nxt = CMD_MODE;
				end
				ST_MODE: begin
					state_nxt = ST_JOIN;
					cmd_nxt = 1'b1;
					idx_nxt = CMD_JOIN;
				end
				ST_JOIN: begin
					state_nxt = ST_CONNECT;
					cmd_nxt = 1'b1;
					idx_nxt = CMD_CONNECT;
				end
				ST_CONNECT: begin
					state_nxt = ST_NETWORK_UP;
				end
				default: begin
					state_nxt = state_q;
				end
			endcase
		end
	end

	always_comb begin
		case (state_nxt)
			ST_ECHO_OFF:   link_nxt = LINK_ECHO_OFF;
			ST_TEST:       link_nxt = LINK_TEST;
			ST_MODE:       link_nxt = LINK_MODE;
			ST_JOIN:       link_nxt = LINK_JOIN;
			ST_CONNECT:    link_nxt = LINK_CONNECT;
			ST_NETWORK_UP: link_nxt = LINK_NETWORK_UP;
			default:       link_nxt = LINK_ECHO_OFF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ECHO_OFF;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ev_take) begin
				state_q <= state_nxt;
				count_q <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_take) begin
			cmd_valid <= cmd_nxt;
			cmd_index <= idx_nxt;
			link_state <= link_nxt;
			sends_confirmed <= count_nxt;
		end
	end

endmodule

@@ src/at_command_link_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// at_command_link_sequencer_top
// Line assembly and bring-up sequencing for an AT-command modem link.
// ----------------------------------------------------------------------------
// Channel | Handshake           | Payload
// input   | in_valid, in_ready   | rx_byte
// output  | out_valid, out_ready | cmd_valid, cmd_index, link_state, sends_confirmed
//
// One byte is taken per cycle while in_ready is high. It enters the queue at the
// edge that accepts it and moves into the result register when the back end
// takes it from the queue, which waits while a held result is not yet accepted.
// The two-entry queue fills only while out_ready is low; in_ready then drops.
// Reset returns the sequence to echo_off, clears the counter and the line.
// ----------------------------------------------------------------------------
module at_command_link_sequencer_top import aclseq_pkg::*; #(
	parameter int MAX_LINE_CHARS = MAX_LINE_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        cmd_valid,
	output logic [1:0]  cmd_index,
	output logic [2:0]  link_state,
	output logic [31:0] sends_confirmed
);

	line_ev_t front_ev;
	line_ev_t queue_ev;
	logic     queue_full;
	logic     queue_avail;
	logic     queue_pop;
	logic     take;

	assign in_ready = !queue_full;
	assign take = in_valid && in_ready;

	aclseq_front #(
		.MAX_LINE_CHARS(MAX_LINE_CHARS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.ev      (front_ev)
	);

	aclseq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_ev   (front_ev),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_avail),
		.pop_ev    (queue_ev)
	);

	aclseq_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.ev_avail        (queue_avail),
		.ev              (queue_ev),
		.ev_take         (queue_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cmd_valid       (cmd_valid),
		.cmd_index       (cmd_index),
		.link_state      (link_state),
		.sends_confirmed (sends_confirmed)
	);

endmodule

@@ src/aclseq_checker.sv @@
// ----------------------------------------------------------------------------
// aclseq_checker
// Port-level checks of the AT-command link sequencer.
// ----------------------------------------------------------------------------
module aclseq_checker import aclseq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        cmd_valid,
	input logic [1:0]  cmd_index,
	input logic [2:0]  link_state,
	input logic [31:0] sends_confirmed
);

	// A stalled result transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cmd_valid) && $stable(cmd_index)
			&& $stable(link_state) && $stable(sends_confirmed))
		else $error("result changed while stalled");

	// A command always names the step that leads to the reported state.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_valid |-> ({1'b0, cmd_index} + 3'd1) == link_state)
		else $error("command index does not match link state");

	// Confirmations are counted only once the network is up.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sends_confirmed != 32'd0) |-> link_state == LINK_NETWORK_UP)
		else $error("send counted before network up");

	// No command is issued once the network is up.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && link_state == LINK_NETWORK_UP |-> !cmd_valid)
		else $error("command issued in network up");

endmodule

bind at_command_link_sequencer_top aclseq_checker u_aclseq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.cmd_valid       (cmd_valid),
	.cmd_index       (cmd_index),
	.link_state      (link_state),
	.sends_confirmed (sends_confirmed)
);

@@ bench/tb_at_command_link_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// tb_at_command_link_sequencer_top
// Self-checking bench for the AT-command link sequencer.
// ----------------------------------------------------------------------------
// Received bytes are built into modem lines and fed to the block. The first
// lines are fixed: empty lines, a zero byte, one near miss, one ignored reply.
// The rest are random. Most are OK and SEND_OK replies, near misses or
// single-character corruptions, and there is one overlong line. A line model
// in the bench gives the status that each byte should produce. Every result
// transaction is checked field by field against that status, in order.
// Both handshakes idle at random, and at times the sender holds back until
// every pending status has come out.
// ----------------------------------------------------------------------------
module tb_at_command_link_sequencer_top;
	import aclseq_pkg::*;

	localparam int LINE_LIMIT = MAX_LINE_CHARS_DEF;
	localparam int BYTE_TARGET = 1700;

	typedef struct packed {
		logic        cmd_valid;
		logic [1:0]  cmd_index;
		logic [2:0]  link_state;
		logic [31:0] sends_confirmed;
	} link_status_t;

	typedef struct {
		logic [7:0] data;
		bit         drain;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        cmd_valid;
	logic [1:0]  cmd_index;
	logic [2:0]  link_state;
	logic [31:0] sends_confirmed;

	rx_item_t     rx_pending[$];
	link_status_t expected_status[$];
	int           fails = 0;

	string ok_text = "OK";
	string sendok_text = "SEND_OK";

	logic [2:0]  link_model = LINK_ECHO_OFF;
	int unsigned line_chars = 0;
	bit          ok_hit = 1'b1;
	bit          sendok_hit = 1'b1;
	logic [31:0] confirmed_model = '0;

	int tx_wait = 0;
	bit tx_burst = 1'b0;
	int rx_wait = 0;
	bit rx_burst = 1'b0;

	at_command_link_sequencer_top #(
		.MAX_LINE_CHARS(LINE_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd_valid(cmd_valid),
		.cmd_index(cmd_index),
		.link_state(link_state),
		.sends_confirmed(sends_confirmed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic link_status_t step_link(input logic [7:0] b);
		link_status_t r;
		r = '0;
		if (b != CHAR_CR && b != CHAR_LF) begin
			if (line_chars < LINE_LIMIT - 1) begin
				if (!(line_chars < 2 && b == ok_text[line_chars]))
					ok_hit = 1'b0;
				if (!(line_chars < 7 && b == sendok_text[line_chars]))
					sendok_hit = 1'b0;
				line_chars++;
			end
		end else if (line_chars != 0) begin
			if (link_model == LINK_NETWORK_UP) begin
				if (sendok_hit && line_chars == 7)
					confirmed_model = confirmed_model + 32'd1;
			end else if (ok_hit && line_chars == 2) begin
				case (link_model)
					LINK_ECHO_OFF: begin
						r.cmd_valid = 1'b1;
						r.cmd_index = CMD_TEST;
						link_model = LINK_TEST;
					end
					LINK_TEST: begin
						r.cmd_valid = 1'b1;
						r.cmd_index = CMD_MODE;
						link_model = LINK_MODE;
					end
					LINK_MODE: begin
						r.cmd_valid = 1'b1;
						r.cmd_index = CMD_JOIN;
						link_model = LINK_JOIN;
					end
					LINK_JOIN: begin
						r.cmd_valid = 1'b1;
						r.cmd_index = CMD_CONNECT;
						link_model = LINK_CONNECT;
					end
					LINK_CONNECT: begin
						link_model = LINK_NETWORK_UP;
					end
					default: begin
					end
				endcase
			end
			line_chars = 0;
			ok_hit = 1'b1;
			sendok_hit = 1'b1;
		end
		r.link_state = link_model;
		r.sends_confirmed = confirmed_model;
		return r;
	endfunction

	task automatic queue_byte(input logic [7:0] b, input bit drain);
		rx_item_t it;
		it.data = b;
		it.drain = drain;
		rx_pending.push_back(it);
	endtask

	task automatic queue_text(input string s, input bit drain);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], drain && i == 0);
	endtask

	task automatic queue_line_end();
		case ($urandom_range(0, 3))
			0: queue_byte(CHAR_CR, 1'b0);
			1: queue_byte(CHAR_LF, 1'b0);
			2: begin
				queue_byte(CHAR_CR, 1'b0);
				queue_byte(CHAR_LF, 1'b0);
			end
			default: begin
				queue_byte(CHAR_LF, 1'b0);
				queue_byte(CHAR_CR, 1'b0);
			end
		endcase
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CHAR_CR || b == CHAR_LF);
		return b;
	endfunction

	task automatic queue_random_line();
		string near_miss[11];
		string s;
		int r;
		int pos;
		bit drain;
		near_miss = '{"O", "K", "OKK", "OOK", "ok", "SEND_O", "SEND_OKK", "SEND-OK",
			"XSEND_OK", "OK_SEND", "SEND_OK "};
		r = $urandom_range(0, 99);
		drain = ($urandom_range(0, 49) == 0);
		if (r < 25) begin
			queue_text(ok_text, drain);
		end else if (r < 50) begin
			queue_text(sendok_text, drain);
		end else if (r < 60) begin
		end else if (r < 75) begin
			queue_text(near_miss[$urandom_range(0, 10)], drain);
		end else if (r < 87) begin
			s = $urandom_range(0, 1) ? ok_text : sendok_text;
			pos = $urandom_range(0, s.len() - 1);
			for (int i = 0; i < s.len(); i++) begin
				if (i == pos) begin
					logic [7:0] b;
					do
						b = text_byte();
					while (b == s[i]);
					queue_byte(b, drain && i == 0);
				end else begin
					queue_byte(s[i], drain && i == 0);
				end
			end
		end else begin
			pos = $urandom_range(1, 12);
			for (int i = 0; i < pos; i++)
				queue_byte(8'($urandom_range(0, 255)), drain && i == 0);
		end
		queue_line_end();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
			tx_wait = 0;
			tx_burst = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_status.push_back(step_link(rx_byte));
				if ($urandom_range(0, 63) == 0)
					tx_burst = !tx_burst;
				tx_wait = tx_burst ? 0 : $urandom_range(0, 10);
			end
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (rx_pending.size() != 0 &&
					(!rx_pending[0].drain || expected_status.size() == 0)) begin
					in_valid <= 1'b1;
					rx_byte <= rx_pending[0].data;
					rx_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
			rx_burst = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					$error("unexpected result transaction: link_state %0d", link_state);
					fails++;
				end else begin
					link_status_t e;
					e = expected_status.pop_front();
					if (cmd_valid !== e.cmd_valid) begin
						$error("cmd_valid: expected %0d, got %0d", e.cmd_valid, cmd_valid);
						fails++;
					end
					if (cmd_index !== e.cmd_index) begin
						$error("cmd_index: expected %0d, got %0d", e.cmd_index, cmd_index);
						fails++;
					end
					if (link_state !== e.link_state) begin
						$error("link_state: expected %0d, got %0d", e.link_state, link_state);
						fails++;
					end
					if (sends_confirmed !== e.sends_confirmed) begin
						$error("sends_confirmed: expected %0d, got %0d",
							e.sends_confirmed, sends_confirmed);
						fails++;
					end
				end
				if ($urandom_range(0, 63) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		bit long_done;
		int long_len;
		long_done = 1'b0;

		// Empty lines, a zero and an all-ones byte, then OK, OKK, SEND_OK and OK.
		queue_byte(CHAR_CR, 1'b0);
		queue_byte(CHAR_LF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(CHAR_CR, 1'b0);
		queue_text(ok_text, 1'b0);
		queue_byte(CHAR_CR, 1'b0);
		queue_text("OKK", 1'b0);
		queue_byte(CHAR_LF, 1'b0);
		queue_text(sendok_text, 1'b0);
		queue_byte(CHAR_CR, 1'b0);
		queue_text(ok_text, 1'b1);
		queue_byte(CHAR_LF, 1'b0);

		while (rx_pending.size() < BYTE_TARGET) begin
			if (!long_done && rx_pending.size() > 700) begin
				// An overlong line that starts like an OK must still not match.
				long_len = $urandom_range(LINE_LIMIT - 1, LINE_LIMIT + 4);
				queue_text(ok_text, 1'b0);
				for (int i = 2; i < long_len; i++)
					queue_byte(text_byte(), 1'b0);
				queue_line_end();
				long_done = 1'b1;
			end else begin
				queue_random_line();
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_pending.size() != 0 || in_valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("at_command_link_sequencer_top verification clean");
		else
			$display("at_command_link_sequencer_top verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("at_command_link_sequencer_top verification failed");
		$finish;
	end

endmodule
